// ===== hw/rtl/acts_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt and rate scaler package
// Shared constants, record types and the arctangent table of the angle cells.
// ----------------------------------------------------------------------------
package acts_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int PRE_SHIFT     = 24 - SAMPLE_BITS;
  localparam int ANGLE_STAGES  = 16;
  localparam int ATAN_LEN      = 24;
  localparam int CORDIC_STAGES = (ANGLE_STAGES > ATAN_LEN) ? ATAN_LEN : ANGLE_STAGES;
  localparam int SQRT_STAGES   = 24;
  localparam int DIV_STAGES    = 25;
  localparam int SUM_W         = 48;
  localparam int XY_W          = 27;
  localparam int Z_W           = 24;
  localparam int NUM_W         = 25;
  localparam int DEN_W         = 15;
  localparam int REM_W         = 16;
  localparam int STEP_W        = 5;

  localparam logic [7:0] REG_GYRO_COUNTS  = 8'd0;
  localparam logic [7:0] REG_ACCEL_COUNTS = 8'd1;

  typedef struct packed {
    logic [SUM_W-1:0]        n;
    logic [SUM_W-1:0]        r;
    logic signed [Z_W-1:0]   y;
  } sqrt_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   nz;
    logic                   rz;
    logic                   neg;
  } cordic_t;

  typedef struct packed {
    logic [NUM_W-1:0] n;
    logic [REM_W-1:0] r;
    logic [NUM_W-1:0] q;
    logic             neg;
  } div_t;

  typedef struct packed {
    logic [2:0][18:0] rate;
    logic [2:0][14:0] acc;
  } scaled_t;

  // Arctangent of 2^-i in units of 1/256 centidegree.
  function automatic logic signed [Z_W-1:0] atan_val(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:    v = 24'sd1152000;
      5'd1:    v = 24'sd680065;
      5'd2:    v = 24'sd359328;
      5'd3:    v = 24'sd182400;
      5'd4:    v = 24'sd91554;
      5'd5:    v = 24'sd45822;
      5'd6:    v = 24'sd22916;
      5'd7:    v = 24'sd11459;
      5'd8:    v = 24'sd5730;
      5'd9:    v = 24'sd2865;
      5'd10:   v = 24'sd1432;
      5'd11:   v = 24'sd716;
      5'd12:   v = 24'sd358;
      5'd13:   v = 24'sd179;
      5'd14:   v = 24'sd90;
      5'd15:   v = 24'sd45;
      5'd16:   v = 24'sd22;
      5'd17:   v = 24'sd11;
      5'd18:   v = 24'sd6;
      5'd19:   v = 24'sd3;
      5'd20:   v = 24'sd1;
      5'd21:   v = 24'sd1;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/accel_tilt_and_rate_scaler.sv =====
// ----------------------------------------------------------------------------
// Accelerometer tilt and rate scaler
// Throughput is one sample per cycle while the output is not stalled, set by
// the square root, vectoring and divider cell rows.
// The whole pipeline holds while a finished result waits on the output.
// Reset clears the pipeline valid bits and loads the sensitivity registers
// with 131 counts per deg/s and 16384 counts per g.
// ----------------------------------------------------------------------------
module accel_tilt_and_rate_scaler (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  input  logic [95:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tilt_about_x, tilt_about_y, rate_x, rate_y, rate_z,
  // accel_x_milli_g, accel_y_milli_g, accel_z_milli_g
  output logic [135:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int CS    = acts_pkg::CORDIC_STAGES;
  localparam int SQ    = acts_pkg::SQRT_STAGES;
  localparam int DV    = acts_pkg::DIV_STAGES;
  localparam int TOTAL = 3 + SQ + CS + 1;

  logic [7:0]                   gyro_counts;
  logic [acts_pkg::DEN_W-1:0]   accel_counts;
  logic [acts_pkg::DEN_W-1:0]   den_g;
  logic [acts_pkg::DEN_W-1:0]   den_a;
  logic [TOTAL-1:0]             vld;
  logic                         en;

  logic signed [15:0]           raw0 [6];
  logic [31:0]                  sq1 [3];
  logic signed [15:0]           ax1;
  logic signed [15:0]           ay1;
  acts_pkg::div_t               din [6];
  acts_pkg::sqrt_t              sc [2][SQ+1];
  acts_pkg::cordic_t            cc [2][CS+1];
  acts_pkg::div_t               dc [6][DV+1];
  acts_pkg::scaled_t            dl [CS];
  acts_pkg::scaled_t            scaled_next;
  logic signed [14:0]           tilt [2];
  logic [135:0]                 out_data;

  assign cfg_ready = 1'b1;
  assign en        = !vld[TOTAL-1] || m_tready;
  assign s_tready  = en;
  assign m_tvalid  = vld[TOTAL-1];
  assign m_tdata   = out_data;
  assign den_g     = (gyro_counts == 8'd0) ? 15'd1 : {7'd0, gyro_counts};
  assign den_a     = (accel_counts == 15'd0) ? 15'd1 : accel_counts;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_counts  <= 8'd131;
      accel_counts <= 15'd16384;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        acts_pkg::REG_GYRO_COUNTS:  gyro_counts  <= cfg_data[7:0];
        acts_pkg::REG_ACCEL_COUNTS: accel_counts <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        raw0[k] <= s_tdata[16*k +: 16];
      end
    end
  end

  // Squares for the radii and rounded numerators for the six divisions.
  always_comb begin
    logic signed [16:0] v;
    logic [16:0]        mag;
    logic [acts_pkg::DEN_W-1:0] dd;
    for (int l = 0; l < 6; l++) begin
      v   = (l < 3) ? 17'(raw0[l+3]) : 17'(raw0[l-3]);
      mag = (v < 0) ? 17'(-v) : 17'(v);
      dd  = (l < 3) ? den_g : den_a;
      din[l].r   = '0;
      din[l].q   = '0;
      din[l].neg = v < 0;
      if (l < 3) begin
        din[l].n = 25'(mag) * 25'd100 + 25'(dd >> 1);
      end else begin
        din[l].n = 25'(mag) * 25'd1000 + 25'(dd >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq1[k] <= 32'(raw0[k] * raw0[k]);
      end
      ax1 <= raw0[0];
      ay1 <= raw0[1];
      for (int l = 0; l < 6; l++) begin
        dc[l][0] <= din[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc[0][0].n <= acts_pkg::SUM_W'({1'b0, sq1[0]} + {1'b0, sq1[2]}) << (2 * acts_pkg::PRE_SHIFT);
      sc[0][0].r <= '0;
      sc[0][0].y <= acts_pkg::Z_W'(ay1) <<< acts_pkg::PRE_SHIFT;
      sc[1][0].n <= acts_pkg::SUM_W'({1'b0, sq1[1]} + {1'b0, sq1[2]}) << (2 * acts_pkg::PRE_SHIFT);
      sc[1][0].r <= '0;
      sc[1][0].y <= acts_pkg::Z_W'(ax1) <<< acts_pkg::PRE_SHIFT;
    end
  end

  for (genvar t = 0; t < 2; t++) begin : g_tilt
    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
      acts_sqrt_cell u_sqrt (
        .clk   (clk),
        .en    (en),
        .step  (acts_pkg::STEP_W'(k)),
        .d_in  (sc[t][k]),
        .d_out (sc[t][k+1])
      );
    end

    always_comb begin
      cc[t][0].x   = $signed({1'b0, sc[t][SQ].r[acts_pkg::XY_W-2:0]});
      cc[t][0].y   = acts_pkg::XY_W'(sc[t][SQ].y);
      cc[t][0].z   = '0;
      cc[t][0].nz  = sc[t][SQ].y != '0;
      cc[t][0].rz  = sc[t][SQ].r == '0;
      cc[t][0].neg = sc[t][SQ].y < 0;
    end

    for (genvar k = 0; k < CS; k++) begin : g_cordic
      acts_cordic_cell u_cordic (
        .clk   (clk),
        .en    (en),
        .step  (acts_pkg::STEP_W'(k)),
        .d_in  (cc[t][k]),
        .d_out (cc[t][k+1])
      );
    end

    always_comb begin
      logic [acts_pkg::Z_W-1:0] zm;
      logic signed [16:0]       a;
      zm = (cc[t][CS].z < 0) ? acts_pkg::Z_W'(-cc[t][CS].z) : acts_pkg::Z_W'(cc[t][CS].z);
      a  = $signed({1'b0, 16'((25'(zm) + 25'd128) >> 8)});
      if (cc[t][CS].z < 0) begin
        a = -a;
      end
      if (a > 17'sd9000) begin
        a = 17'sd9000;
      end else if (a < -17'sd9000) begin
        a = -17'sd9000;
      end
      if (!cc[t][CS].nz) begin
        tilt[t] = '0;
      end else if (cc[t][CS].rz) begin
        tilt[t] = cc[t][CS].neg ? -15'sd9000 : 15'sd9000;
      end else begin
        tilt[t] = 15'(a);
      end
    end
  end

  for (genvar l = 0; l < 6; l++) begin : g_lane
    for (genvar k = 0; k < DV; k++) begin : g_div
      acts_div_cell u_div (
        .clk   (clk),
        .en    (en),
        .den   ((l < 3) ? den_g : den_a),
        .d_in  (dc[l][k]),
        .d_out (dc[l][k+1])
      );
    end
  end

  always_comb begin
    logic signed [25:0] q;
    for (int l = 0; l < 6; l++) begin
      q = $signed({1'b0, dc[l][DV].q});
      if (dc[l][DV].neg) begin
        q = -q;
      end
      if (l < 3) begin
        if (q > 26'sd204800) begin
          q = 26'sd204800;
        end else if (q < -26'sd204800) begin
          q = -26'sd204800;
        end
        scaled_next.rate[l] = 19'(q);
      end else begin
        if (q > 26'sd16000) begin
          q = 26'sd16000;
        end else if (q < -26'sd16000) begin
          q = -26'sd16000;
        end
        scaled_next.acc[l-3] = 15'(q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= scaled_next;
      for (int k = 1; k < CS; k++) begin
        dl[k] <= dl[k-1];
      end
      out_data <= {4'd0, dl[CS-1].acc[2], dl[CS-1].acc[1], dl[CS-1].acc[0],
                   dl[CS-1].rate[2], dl[CS-1].rate[1], dl[CS-1].rate[0],
                   tilt[1], tilt[0]};
    end
  end

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted transaction did not enter the pipeline");

  a_tilt_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[14:0]) >= -15'sd9000 &&
                  $signed(m_tdata[14:0]) <= 15'sd9000 &&
                  $signed(m_tdata[29:15]) >= -15'sd9000 &&
                  $signed(m_tdata[29:15]) <= 15'sd9000))
    else $error("tilt result out of range");

  a_rate_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[48:30]) >= -19'sd204800 &&
                  $signed(m_tdata[48:30]) <= 19'sd204800))
    else $error("rate result out of range");

endmodule

// ===== hw/rtl/acts_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// One digit step of the integer square root, registered.
// ----------------------------------------------------------------------------
module acts_sqrt_cell (
  input  logic                              clk,
  input  logic                              en,
  input  logic [acts_pkg::STEP_W-1:0]       step,
  input  acts_pkg::sqrt_t                   d_in,
  output acts_pkg::sqrt_t                   d_out
);

  logic [acts_pkg::SUM_W-1:0] bitv;
  logic [acts_pkg::SUM_W-1:0] trial;
  acts_pkg::sqrt_t            nxt;

  always_comb begin
    bitv  = acts_pkg::SUM_W'(1) << (6'(acts_pkg::SUM_W - 2) - {step, 1'b0});
    trial = d_in.r + bitv;
    nxt   = d_in;
    if (d_in.n >= trial) begin
      nxt.n = d_in.n - trial;
      nxt.r = (d_in.r >> 1) + bitv;
    end else begin
      nxt.r = d_in.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
  end

endmodule

// ===== hw/rtl/acts_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// Vectoring cell
// One rotation step of the arctangent unit, registered.
// ----------------------------------------------------------------------------
module acts_cordic_cell (
  input  logic                              clk,
  input  logic                              en,
  input  logic [acts_pkg::STEP_W-1:0]       step,
  input  acts_pkg::cordic_t                 d_in,
  output acts_pkg::cordic_t                 d_out
);

  logic signed [acts_pkg::XY_W-1:0] dx;
  logic signed [acts_pkg::XY_W-1:0] dy;
  acts_pkg::cordic_t                nxt;

  always_comb begin
    dx  = d_in.x >>> step;
    dy  = d_in.y >>> step;
    nxt = d_in;
    if (d_in.y > 0) begin
      nxt.x = d_in.x + dy;
      nxt.y = d_in.y - dx;
      nxt.z = d_in.z + acts_pkg::atan_val(step);
    end else begin
      nxt.x = d_in.x - dy;
      nxt.y = d_in.y + dx;
      nxt.z = d_in.z - acts_pkg::atan_val(step);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
  end

endmodule

// ===== hw/rtl/acts_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One quotient bit of a restoring division, registered.
// ----------------------------------------------------------------------------
module acts_div_cell (
  input  logic                              clk,
  input  logic                              en,
  input  logic [acts_pkg::DEN_W-1:0]        den,
  input  acts_pkg::div_t                    d_in,
  output acts_pkg::div_t                    d_out
);

  logic [acts_pkg::REM_W-1:0] rs;
  acts_pkg::div_t             nxt;

  always_comb begin
    rs  = {d_in.r[acts_pkg::REM_W-2:0], d_in.n[acts_pkg::NUM_W-1]};
    nxt = d_in;
    nxt.n = d_in.n << 1;
    if (rs >= {1'b0, den}) begin
      nxt.r = rs - {1'b0, den};
      nxt.q = {d_in.q[acts_pkg::NUM_W-2:0], 1'b1};
    end else begin
      nxt.r = rs;
      nxt.q = {d_in.q[acts_pkg::NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
  end

endmodule

// ===== bench/tilt_rate_checker.sv =====
// ----------------------------------------------------------------------------
// Tilt and rate scaler checker
// Watches the sample, result and register channels, computes the expected
// tilt angles, rates and milli-g values, and compares each result in order.
// ----------------------------------------------------------------------------
module tilt_rate_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [95:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [135:0] m_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]   gyro_div;
  logic [14:0]  accel_div;
  logic [135:0] sample_results[$];

  function automatic longint div_nearest(longint num, longint den);
    longint mag;
    if (den == 0) den = 1;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint limit(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint root_floor(longint n);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic longint tilt_angle(longint num, longint a, longint b);
    longint sa, sb, x, y, z, nx, ny;
    sa = a <<< acts_pkg::PRE_SHIFT;
    sb = b <<< acts_pkg::PRE_SHIFT;
    y = num <<< acts_pkg::PRE_SHIFT;
    z = 0;
    if (num == 0) return 0;
    x = root_floor(sa * sa + sb * sb);
    if (x == 0) return num > 0 ? 9000 : -9000;
    for (int i = 0; i < acts_pkg::CORDIC_STAGES; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + acts_pkg::atan_val(acts_pkg::STEP_W'(i));
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - acts_pkg::atan_val(acts_pkg::STEP_W'(i));
      end
      x = nx;
      y = ny;
    end
    return limit(div_nearest(z, 256), -9000, 9000);
  endfunction

  function automatic logic [135:0] scale_sample(logic [95:0] d);
    longint ax, ay, az, g, v;
    logic [135:0] r;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    r = '0;
    v = tilt_angle(ay, ax, az); r[14:0] = v[14:0];
    v = tilt_angle(ax, ay, az); r[29:15] = v[14:0];
    for (int k = 0; k < 3; k++) begin
      g = longint'($signed(d[48 + 16*k +: 16]));
      v = limit(div_nearest(g * 100, gyro_div), -204800, 204800);
      r[30 + 19*k +: 19] = v[18:0];
    end
    v = limit(div_nearest(ax * 1000, accel_div), -16000, 16000); r[101:87] = v[14:0];
    v = limit(div_nearest(ay * 1000, accel_div), -16000, 16000); r[116:102] = v[14:0];
    v = limit(div_nearest(az * 1000, accel_div), -16000, 16000); r[131:117] = v[14:0];
    return r;
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    logic [135:0] want;
    if (rst) begin
      gyro_div <= 8'd131;
      accel_div <= 15'd16384;
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == acts_pkg::REG_GYRO_COUNTS) gyro_div <= cfg_data[7:0];
        else if (cfg_index == acts_pkg::REG_ACCEL_COUNTS) accel_div <= cfg_data[14:0];
      end
      if (s_tvalid && s_tready) sample_results.push_back(scale_sample(s_tdata));
      if (m_tvalid && m_tready) begin
        if (sample_results.size() == 0) begin
          $error("result transaction with no sample outstanding");
          errors++;
        end else begin
          want = sample_results.pop_front();
          compare_field("tilt_about_x", $signed(want[14:0]), $signed(m_tdata[14:0]));
          compare_field("tilt_about_y", $signed(want[29:15]), $signed(m_tdata[29:15]));
          compare_field("rate_x", $signed(want[48:30]), $signed(m_tdata[48:30]));
          compare_field("rate_y", $signed(want[67:49]), $signed(m_tdata[67:49]));
          compare_field("rate_z", $signed(want[86:68]), $signed(m_tdata[86:68]));
          compare_field("accel_x_milli_g", $signed(want[101:87]),
                        $signed(m_tdata[101:87]));
          compare_field("accel_y_milli_g", $signed(want[116:102]),
                        $signed(m_tdata[116:102]));
          compare_field("accel_z_milli_g", $signed(want[131:117]),
                        $signed(m_tdata[131:117]));
          compare_field("pad", 0, m_tdata[135:132]);
        end
      end
      pending <= sample_results.size();
    end
  end

endmodule

// ===== bench/tb_accel_tilt_and_rate_scaler.sv =====
// ----------------------------------------------------------------------------
// Tilt and rate scaler testbench
// Drives directed and random motion samples through several sensitivity
// settings with bursty input and stalling output; the checker judges results.
// ----------------------------------------------------------------------------
module tb_accel_tilt_and_rate_scaler;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;
  int           errors;
  int           pending;
  bit           hold_off = 1'b0;

  always #5 clk = ~clk;

  accel_tilt_and_rate_scaler u_top (.*);
  tilt_rate_checker u_check (.*);

  function automatic logic [15:0] axis_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(logic [95:0] d);
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random(int count);
    logic [95:0] d;
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && count > 0) begin
        for (int k = 0; k < 6; k++) d[16*k +: 16] = axis_value();
        send_sample(d);
        burst--;
        count--;
      end
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_off) m_tready <= 1'b0;
    else if (($urandom_range(0, 99) < 30) && ($urandom_range(0, 3) != 0))
      m_tready <= 1'b0;
    else m_tready <= 1'b1;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_sample(96'h0);
    send_sample({48'h0, 16'h0, 16'h0, 16'h1234});
    send_sample({48'h0, 16'h0, 16'h0, 16'h8000});
    send_sample({48'h0, 16'h0, 16'hFFFF, 16'h0});
    send_sample({48'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    send_sample({48'h0, 16'h8000, 16'h8000, 16'h8000});
    send_sample({16'h7FFF, 16'h8000, 16'h0001, 48'h0});
    send_sample({16'hFFFF, 16'h0001, 16'h8000, 16'h0001, 16'hFFFF, 16'h4000});
    send_sample({16'h8000, 16'h7FFF, 16'hFFFF, 16'hC000, 16'h0001, 16'h0});
    s_tvalid <= 1'b0;
    write_reg(acts_pkg::REG_GYRO_COUNTS, 16'd16);
    write_reg(acts_pkg::REG_ACCEL_COUNTS, 16'd2048);
    send_sample({16'h8000, 16'h7FFF, 16'h0041, 16'h8000, 16'h7FFF, 16'h0400});
    send_sample({16'h7FFF, 16'h8000, 16'hFFBF, 16'h7FFF, 16'h8000, 16'hFC00});
    s_tvalid <= 1'b0;
    write_reg(acts_pkg::REG_GYRO_COUNTS, 16'd0);
    write_reg(acts_pkg::REG_ACCEL_COUNTS, 16'd0);
    send_sample({16'h0032, 16'hFFCE, 16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF});
    s_tvalid <= 1'b0;
    write_reg(acts_pkg::REG_ACCEL_COUNTS + 8'd1, 16'hFFFF);
    write_reg(acts_pkg::REG_GYRO_COUNTS, 16'hFF83);
    write_reg(acts_pkg::REG_ACCEL_COUNTS, 16'hFFFF);
    send_random(300);
    write_reg(acts_pkg::REG_GYRO_COUNTS, 16'd131);
    write_reg(acts_pkg::REG_ACCEL_COUNTS, 16'd16384);
    fork
      send_random(300);
      begin
        repeat (20) @(posedge clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge clk);
        hold_off <= 1'b0;
      end
    join
    write_reg(acts_pkg::REG_GYRO_COUNTS, 16'd16);
    write_reg(acts_pkg::REG_ACCEL_COUNTS, 16'd2048);
    send_random(300);
    for (int p = 0; p < 3; p++) begin
      write_reg(acts_pkg::REG_GYRO_COUNTS, 16'($urandom_range(0, 255)));
      write_reg(acts_pkg::REG_ACCEL_COUNTS, 16'($urandom));
      send_random(170);
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("tb_accel_tilt_and_rate_scaler: done, clean");
    else $display("tb_accel_tilt_and_rate_scaler: done, errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_accel_tilt_and_rate_scaler: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/acts_pkg.sv
hw/rtl/acts_sqrt_cell.sv
hw/rtl/acts_cordic_cell.sv
hw/rtl/acts_div_cell.sv
hw/rtl/accel_tilt_and_rate_scaler.sv
bench/tilt_rate_checker.sv
bench/tb_accel_tilt_and_rate_scaler.sv
